// ===== src/abp_pkg.sv =====
`default_nettype none
package abp_pkg;

  localparam int BITS      = 8;
  localparam int WAYS      = 4;
  localparam int RAS_DEPTH = 16;

  localparam int NSETS = 1 << BITS;
  localparam int NENT  = NSETS * WAYS;
  localparam int SET_W = BITS;
  localparam int IDX_W = $clog2(NENT);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SP_W  = (RAS_DEPTH > 1) ? $clog2(RAS_DEPTH) : 1;
  localparam int CNT_W = $clog2(RAS_DEPTH + 1);
  localparam int CTR_W = 3;

  localparam logic [1:0] BIAS_UNSET = 2'd2;

  localparam logic [CTR_W-1:0] CTR_MAX    = 3'd4;
  localparam logic [CTR_W-1:0] CTR_INIT   = 3'd1;
  localparam logic [CTR_W-1:0] CTR_THRESH = 3'd2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [63:0]     tag;
    logic [63:0]     target;
    logic [BITS-1:0] ci;
    logic [1:0]      bias;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic clear;
    logic load;
    logic search;
    logic wp_wr;
    logic ent_lat;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic miss;
    logic op_update;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/abp_ram.sv =====
`default_nettype none
module abp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/abp_datapath.sv =====
`default_nettype none
module abp_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [135:0]  s_tdata,
  input  wire logic          s_tuser,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata,
  input  wire abp_pkg::cmd_t cmd,
  output abp_pkg::sts_t      sts
);

  localparam int BITS = abp_pkg::BITS;
  localparam int IDX_W = abp_pkg::IDX_W;
  localparam int SP_W = abp_pkg::SP_W;
  localparam int CNT_W = abp_pkg::CNT_W;
  localparam int CTR_W = abp_pkg::CTR_W;
  localparam int WAY_W = abp_pkg::WAY_W;
  localparam int SET_W = abp_pkg::SET_W;

  logic              op;
  logic [63:0]       pc;
  logic              is_ret;
  logic              is_call;
  logic              a_taken;
  logic [63:0]       a_target;
  logic [IDX_W:0]    saddr;
  logic              rvalid;
  logic [IDX_W-1:0]  ridx;
  logic [IDX_W-1:0]  clr_addr;
  logic              found;
  abp_pkg::ent_t     ent;
  logic [IDX_W-1:0]  eidx;
  logic [BITS-1:0]   gh;
  logic [BITS-1:0]   th;
  logic [63:0]       stack [abp_pkg::RAS_DEPTH];
  logic [SP_W-1:0]   head;
  logic [CNT_W-1:0]  count;
  logic              out_taken;
  logic [63:0]       out_target;

  abp_pkg::ent_t     ent_q;
  abp_pkg::ent_t     ent_wdata;
  abp_pkg::ent_t     ent_pred;
  abp_pkg::ent_t     ent_upd;
  logic              ent_we;
  logic [IDX_W-1:0]  ent_waddr;
  logic [IDX_W-1:0]  ent_raddr;
  logic [WAY_W-1:0]  wp_q;
  logic [WAY_W-1:0]  way_next;
  logic              wp_we;
  logic [SET_W-1:0]  wp_waddr;
  logic [WAY_W-1:0]  wp_wdata;
  logic [CTR_W-1:0]  ctr;
  logic [CTR_W-1:0]  ctr_new;
  logic              cnt_we;
  logic [SET_W-1:0]  cnt_waddr;
  logic [CTR_W-1:0]  cnt_wdata;
  logic [SET_W-1:0]  cnt_raddr;
  logic [SET_W-1:0]  set;
  logic [BITS-1:0]   ci_pred;
  logic              clr_low;
  logic              match;
  logic              ret_path;
  logic [SP_W-1:0]   hm1;
  logic [SP_W-1:0]   h1;
  logic [SP_W-1:0]   h1p;
  logic [CNT_W-1:0]  c1;
  logic              pred_taken;
  logic [1:0]        bias_new;
  logic              agree;
  logic              exec_pred;

  assign set       = th ^ gh ^ pc[BITS-1:0];
  assign ci_pred   = gh ^ pc[BITS-1:0];
  assign clr_low   = ({1'b0, clr_addr} < (IDX_W+1)'(abp_pkg::NSETS));
  assign match     = rvalid && ent_q.valid && (ent_q.tag == pc);
  assign exec_pred = cmd.exec && (op == abp_pkg::OP_PREDICT);

  assign ret_path = is_ret && (count != '0);
  assign hm1      = (head == '0) ? SP_W'(abp_pkg::RAS_DEPTH - 1) : head - 1'b1;
  assign h1       = ret_path ? hm1 : head;
  assign c1       = ret_path ? count - 1'b1 : count;
  assign h1p      = (h1 == SP_W'(abp_pkg::RAS_DEPTH - 1)) ? '0 : h1 + 1'b1;

  assign way_next = (wp_q == WAY_W'(abp_pkg::WAYS - 1)) ? '0 : wp_q + 1'b1;

  always_comb begin
    if (ent.bias == abp_pkg::BIAS_UNSET) begin
      pred_taken = 1'b0;
    end else if (ctr >= abp_pkg::CTR_THRESH) begin
      pred_taken = ent.bias[0];
    end else begin
      pred_taken = ~ent.bias[0];
    end
    ent_pred    = ent;
    // the stack path leaves the stored counter index alone
    ent_pred.ci = ret_path ? ent.ci : ci_pred;

    bias_new = (ent.bias == abp_pkg::BIAS_UNSET) ? {1'b0, a_taken} : ent.bias;
    agree    = (bias_new == {1'b0, a_taken});
    if (agree) begin
      ctr_new = (ctr == abp_pkg::CTR_MAX) ? ctr : ctr + 1'b1;
    end else begin
      ctr_new = (ctr == '0) ? ctr : ctr - 1'b1;
    end
    ent_upd        = ent;
    ent_upd.bias   = bias_new;
    ent_upd.target = a_taken ? a_target : ent.target;
  end

  assign ent_raddr = cmd.search ? saddr[IDX_W-1:0] : eidx;
  assign ent_we    = cmd.clear || (cmd.exec && found);
  assign ent_waddr = cmd.clear ? clr_addr : eidx;
  assign ent_wdata = cmd.clear ? abp_pkg::ent_t'('0) : (op ? ent_upd : ent_pred);

  assign wp_we    = (cmd.clear && clr_low) || cmd.wp_wr;
  assign wp_waddr = cmd.clear ? clr_addr[SET_W-1:0] : set;
  assign wp_wdata = cmd.clear ? '0 : way_next;

  assign cnt_raddr = op ? ent.ci : ci_pred;
  assign cnt_we    = (cmd.clear && clr_low) || (cmd.exec && op && found);
  assign cnt_waddr = cmd.clear ? clr_addr[SET_W-1:0] : ent.ci;
  assign cnt_wdata = cmd.clear ? abp_pkg::CTR_INIT : ctr_new;

  abp_ram #(.WIDTH(abp_pkg::ENT_W), .DEPTH(abp_pkg::NENT)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  abp_ram #(.WIDTH(WAY_W), .DEPTH(abp_pkg::NSETS)) u_wp_ram (
    .clk   (clk),
    .we    (wp_we),
    .waddr (wp_waddr),
    .wdata (wp_wdata),
    .raddr (set),
    .rdata (wp_q)
  );

  abp_ram #(.WIDTH(CTR_W), .DEPTH(abp_pkg::NSETS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (ctr)
  );

  always_ff @(posedge clk) begin
    if (exec_pred && is_call) begin
      stack[h1] <= pc + 64'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rvalid   <= 1'b0;
      saddr    <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
      head     <= '0;
      gh       <= '0;
      th       <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        op       <= s_tuser;
        pc       <= s_tdata[63:0];
        is_ret   <= s_tdata[64];
        is_call  <= s_tdata[65];
        a_taken  <= s_tdata[66];
        a_target <= s_tdata[130:67];
        saddr    <= '0;
        found    <= 1'b0;
      end
      rvalid <= cmd.search && (saddr < (IDX_W+1)'(abp_pkg::NENT));
      if (cmd.search) begin
        saddr <= saddr + 1'b1;
        ridx  <= saddr[IDX_W-1:0];
        if (match) begin
          ent   <= ent_q;
          eidx  <= ridx;
          found <= 1'b1;
        end
      end
      if (cmd.wp_wr) begin
        eidx <= IDX_W'(int'(set) * abp_pkg::WAYS + int'(way_next));
      end
      if (cmd.ent_lat) begin
        // a fresh entry keeps the old occupant's target and counter index
        ent.valid  <= 1'b1;
        ent.tag    <= pc;
        ent.target <= ent_q.target;
        ent.ci     <= ent_q.ci;
        ent.bias   <= abp_pkg::BIAS_UNSET;
        found      <= 1'b1;
      end
      if (m_tvalid && m_tready && !exec_pred) begin
        m_tvalid <= 1'b0;
      end
      if (exec_pred) begin
        m_tvalid   <= 1'b1;
        out_taken  <= ret_path ? 1'b1 : pred_taken;
        out_target <= ret_path ? stack[hm1] : ent.target;
        head       <= is_call ? h1p : h1;
        if (is_call) begin
          count <= (c1 == CNT_W'(abp_pkg::RAS_DEPTH)) ? c1 : c1 + 1'b1;
        end else begin
          count <= c1;
        end
      end
      if (cmd.exec && op) begin
        th <= a_target[BITS-1:0];
        gh <= {gh[BITS-2:0], a_taken};
      end
    end
  end

  assign m_tdata = {7'b0, out_target, out_taken};

  assign sts.clear_done = (clr_addr == IDX_W'(abp_pkg::NENT - 1));
  assign sts.hit        = match;
  assign sts.miss       = rvalid && !match && (ridx == IDX_W'(abp_pkg::NENT - 1));
  assign sts.op_update  = op;
  assign sts.out_busy   = m_tvalid && !m_tready;

  a_pred_out: assert property (@(posedge clk) disable iff (rst)
    exec_pred |=> m_tvalid)
    else $error("prediction not presented");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.search && match) |=> (ent.valid && found))
    else $error("hit latched an invalid entry");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (exec_pred && is_call && !ret_path && count == CNT_W'(abp_pkg::RAS_DEPTH))
    |=> (count == CNT_W'(abp_pkg::RAS_DEPTH)))
    else $error("full stack push changed depth");

endmodule
`default_nettype wire

// ===== src/abp_ctrl.sv =====
`default_nettype none
module abp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output abp_pkg::cmd_t      cmd,
  input  wire abp_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    CLEAR, IDLE, SEARCH, WP_RD, WP_WR, ENT_RD, ENT_LAT, CNT_RD, EXEC
  } state_t;

  state_t state;
  logic   exec_go;

  assign exec_go  = !(!sts.op_update && sts.out_busy);
  assign s_tready = (state == IDLE);

  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == CLEAR);
    cmd.load    = (state == IDLE) && s_tvalid;
    cmd.search  = (state == SEARCH);
    cmd.wp_wr   = (state == WP_WR);
    cmd.ent_lat = (state == ENT_LAT);
    cmd.exec    = (state == EXEC) && exec_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      case (state)
        CLEAR: begin
          if (sts.clear_done) state <= IDLE;
        end
        IDLE: begin
          if (s_tvalid) state <= SEARCH;
        end
        SEARCH: begin
          if (sts.hit) begin
            state <= CNT_RD;
          end else if (sts.miss) begin
            state <= sts.op_update ? CNT_RD : WP_RD;
          end
        end
        WP_RD:   state <= WP_WR;
        WP_WR:   state <= ENT_RD;
        ENT_RD:  state <= ENT_LAT;
        ENT_LAT: state <= CNT_RD;
        CNT_RD:  state <= EXEC;
        EXEC: begin
          // hold a predict while the previous result is still unclaimed
          if (exec_go) state <= IDLE;
        end
        default: state <= CLEAR;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.load, cmd.search, cmd.wp_wr, cmd.ent_lat, cmd.exec}))
    else $error("conflicting commands");

  a_load_search: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.search)
    else $error("search did not follow load");

  a_exec_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> s_tready)
    else $error("not idle after execute");

endmodule
`default_nettype wire

// ===== src/agree_branch_predictor_btb_ras.sv =====
// Agree branch predictor with a set-associative target buffer and return stack.
// Input channel s_*: one item per predict or update. s_tuser carries the
// operation (0 predict, 1 update); s_tdata carries pc, is_return, is_call,
// actual_taken and actual_target.
// Output channel m_*: one result per predict item, none per update item.
// After reset a clearing pass writes every one of the 1024 buffer entries, every
// way pointer and every counter while s_tready stays low.
// Each item is handled alone. The valid tags are searched in order through
// the entry memory's single read port, one entry a cycle. A predict that
// misses then allocates an entry (way pointer read, entry read); an update
// that misses allocates none. The worst case per item is set by that search.
// A result waits in the output register until taken; the next item may be
// accepted meanwhile, and a predict is held at its final step while that result is still untaken.
`default_nettype none
module agree_branch_predictor_btb_ras (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [63:0] pc, [64] is_return, [65] is_call, [66] actual_taken,
  // [130:67] actual_target, [135:131] zero
  input  wire logic [135:0] s_tdata,
  // [0] operation
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [0] predicted_taken, [64:1] predicted_target, [71:65] zero
  output logic [71:0]       m_tdata
);

  abp_pkg::cmd_t cmd;
  abp_pkg::sts_t sts;

  abp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  abp_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire
